// ===== src/triangle_perspective_projection_top_assert.svh =====
// assertion macros used by the checker of this block
`ifndef TRIANGLE_PERSPECTIVE_PROJECTION_TOP_ASSERT_SVH
`define TRIANGLE_PERSPECTIVE_PROJECTION_TOP_ASSERT_SVH

// overlapping implication, sampled on clock, off while reset is high
`define TPP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// a condition that must never be seen out of reset
`define TPP_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// ===== src/tpp_pkg.sv =====
package tpp_pkg;

   localparam int LANES   = 6;
   localparam int CELLS   = 8;
   localparam int LATENCY = CELLS + 3;
   localparam int QUO_W   = 8;
   localparam int REM_W   = 23;
   localparam int DVS_W   = 22;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic signed [35:0] normal_depth;
      logic [7:0]         colour_in;
   } tpp_req_type;

   typedef struct packed {
      logic [7:0] pa_col;
      logic [7:0] pa_row;
      logic [7:0] pb_col;
      logic [7:0] pb_row;
      logic [7:0] pc_col;
      logic [7:0] pc_row;
      logic [7:0] colour_out;
      logic [1:0] shade_level;
      logic       depth_fault;
   } tpp_rsp_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
      logic             force_zero;
      logic             force_max;
   } tpp_lane_type;

   typedef struct packed {
      logic                          valid;
      tpp_lane_type [LANES-1:0]      lane;
      logic [7:0]                    colour;
      logic [1:0]                    shade;
      logic                          fault;
   } tpp_stage_type;

   typedef enum logic [1:0] {
      REG_X_SCALE    = 2'd0,
      REG_Y_SCALE    = 2'd1,
      REG_SHADE_LOW  = 2'd2,
      REG_SHADE_HIGH = 2'd3
   } tpp_csr_reg_type;

   localparam logic [1:0] SHADE_DIM = 2'd1;
   localparam logic [1:0] SHADE_MID = 2'd2;
   localparam logic [1:0] SHADE_HI  = 2'd3;

endpackage

// ===== src/tpp_front.sv =====
module tpp_front #(
   parameter int FRAME_COLS = 96,
   parameter int FRAME_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  tpp_pkg::tpp_req_type req,
   input  logic [15:0]          x_scale,
   input  logic [15:0]          y_scale,
   input  logic [34:0]          thr_low,
   input  logic [34:0]          thr_high,
   output tpp_pkg::tpp_stage_type stage_out
);
   import tpp_pkg::*;

   localparam logic signed [10:0] COL_MUL = 11'(2 * FRAME_COLS);
   localparam logic signed [10:0] ROW_MUL = 11'(2 * FRAME_ROWS);
   localparam logic signed [10:0] COL_OFS = 11'(2 * (FRAME_COLS / 2) + 1);
   localparam logic signed [10:0] ROW_OFS = 11'(2 * (FRAME_ROWS / 2) + 1);

   logic signed [15:0] vx [3];
   logic signed [15:0] vy [3];
   logic signed [15:0] vz [3];

   logic signed [32:0] sv_in [LANES];
   logic signed [32:0] sv_ff [LANES];
   logic signed [15:0] z_ff  [3];
   logic [2:0]         fault_in, fault_ff;
   logic [35:0]        mag;
   logic [1:0]         shade_in, shade_ff;
   logic [7:0]         colour_ff;
   logic               valid_ff;
   logic signed [42:0] t   [LANES];
   logic signed [29:0] tq  [LANES];
   logic [14:0]        zu  [LANES];
   logic               big [LANES];
   tpp_stage_type      stage_in, stage_ff;

   assign vx[0] = req.ax;
   assign vy[0] = req.ay;
   assign vz[0] = req.az;
   assign vx[1] = req.bx;
   assign vy[1] = req.by;
   assign vz[1] = req.bz;
   assign vx[2] = req.cx;
   assign vy[2] = req.cy;
   assign vz[2] = req.cz;

   // scale times coordinate, one multiplier per lane
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         sv_in[2*v]   = $signed({1'b0, x_scale}) * vx[v];
         sv_in[2*v+1] = $signed({1'b0, y_scale}) * vy[v];
         fault_in[v]  = vz[v][15] || (vz[v] == 16'sd0);
      end
      mag = req.normal_depth[35] ? 36'(-req.normal_depth) : 36'(req.normal_depth);
      if (mag < {1'b0, thr_low}) begin
         shade_in = SHADE_DIM;
      end else if (mag < {1'b0, thr_high}) begin
         shade_in = SHADE_MID;
      end else begin
         shade_in = SHADE_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      sv_ff     <= sv_in;
      z_ff      <= vz;
      fault_ff  <= fault_in;
      shade_ff  <= shade_in;
      colour_ff <= req.colour_in;
   end

   // numerator 2*s*v*F + (2*floor(F/2)+1)*4096*z, then drop the 13 zero bits of the divisor
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         t[k] = 43'(sv_ff[k]) * 43'(k[0] ? ROW_MUL : COL_MUL)
              + 43'(k[0] ? ROW_OFS : COL_OFS) * (43'(z_ff[k >> 1]) <<< 12);
         tq[k]  = t[k][42:13];
         zu[k]  = z_ff[k >> 1][14:0];
         big[k] = !t[k][42] && (tq[k][29:0] >= {7'b0, zu[k], 8'b0});
         stage_in.lane[k].rem        = tq[k][REM_W-1:0];
         stage_in.lane[k].dvs        = {zu[k], 7'b0};
         stage_in.lane[k].quo        = '0;
         stage_in.lane[k].force_zero = fault_ff[k >> 1] || t[k][42];
         stage_in.lane[k].force_max  = big[k];
      end
      stage_in.valid  = valid_ff;
      stage_in.colour = colour_ff;
      stage_in.shade  = shade_ff;
      stage_in.fault  = |fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.lane   <= stage_in.lane;
      stage_ff.colour <= stage_in.colour;
      stage_ff.shade  <= stage_in.shade;
      stage_ff.fault  <= stage_in.fault;
   end

   assign stage_out = stage_ff;

endmodule

// ===== src/tpp_div_cell.sv =====
module tpp_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tpp_pkg::tpp_stage_type stage_in,
   output tpp_pkg::tpp_stage_type stage_out
);
   import tpp_pkg::*;

   tpp_stage_type next_in, cell_ff;

   // one restoring quotient bit per lane, divisor halves on its way down
   always_comb begin
      next_in = stage_in;
      for (int k = 0; k < LANES; k++) begin
         if (stage_in.lane[k].rem >= {1'b0, stage_in.lane[k].dvs}) begin
            next_in.lane[k].rem = stage_in.lane[k].rem - {1'b0, stage_in.lane[k].dvs};
            next_in.lane[k].quo = {stage_in.lane[k].quo[QUO_W-2:0], 1'b1};
         end else begin
            next_in.lane[k].quo = {stage_in.lane[k].quo[QUO_W-2:0], 1'b0};
         end
         next_in.lane[k].dvs = stage_in.lane[k].dvs >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= next_in.valid;
      end
      cell_ff.lane   <= next_in.lane;
      cell_ff.colour <= next_in.colour;
      cell_ff.shade  <= next_in.shade;
      cell_ff.fault  <= next_in.fault;
   end

   assign stage_out = cell_ff;

endmodule

// ===== src/triangle_perspective_projection_top.sv =====
// channel   | ports                                  | direction
// request   | start, busy, req_data                  | in
// result    | rsp_valid, rsp_data                    | out
// registers | psel, penable, pwrite, paddr, pwdata,  | in/out
//           | prdata, pready                         |
// one triangle taken every cycle; busy is never raised
// the result passes through the two front stages,
// the chain of eight divider cells (one quotient bit each) and the output register
// reset is synchronous and empties the pipeline; registers return to defaults
// results cannot be stalled by the receiver
module triangle_perspective_projection_top #(
   parameter int FRAME_COLS = 96,
   parameter int FRAME_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tpp_pkg::tpp_req_type req_data,
   output logic                 rsp_valid,
   output tpp_pkg::tpp_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready
);
   import tpp_pkg::*;

   logic [15:0]     x_scale_ff, y_scale_ff;
   logic [34:0]     thr_low_ff, thr_high_ff;
   tpp_csr_reg_type reg_sel;
   logic            wr_en;
   tpp_stage_type   chain [CELLS+1];
   logic [7:0]      pix [LANES];
   logic            rsp_valid_ff;
   tpp_rsp_type     rsp_data_ff, rsp_data_in;

   assign busy    = 1'b0;
   assign pready  = 1'b1;
   assign reg_sel = tpp_csr_reg_type'(paddr[4:3]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff  <= 16'd4096;
         y_scale_ff  <= 16'd4096;
         thr_low_ff  <= '0;
         thr_high_ff <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_X_SCALE:    x_scale_ff  <= pwdata[15:0];
            REG_Y_SCALE:    y_scale_ff  <= pwdata[15:0];
            REG_SHADE_LOW:  thr_low_ff  <= pwdata[34:0];
            REG_SHADE_HIGH: thr_high_ff <= pwdata[34:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_X_SCALE:    prdata = {48'b0, x_scale_ff};
         REG_Y_SCALE:    prdata = {48'b0, y_scale_ff};
         REG_SHADE_LOW:  prdata = {29'b0, thr_low_ff};
         REG_SHADE_HIGH: prdata = {29'b0, thr_high_ff};
         default:        prdata = '0;
      endcase
   end

   tpp_front #(
      .FRAME_COLS(FRAME_COLS),
      .FRAME_ROWS(FRAME_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .req      (req_data),
      .x_scale  (x_scale_ff),
      .y_scale  (y_scale_ff),
      .thr_low  (thr_low_ff),
      .thr_high (thr_high_ff),
      .stage_out(chain[0])
   );

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      tpp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .stage_in (chain[c]),
         .stage_out(chain[c+1])
      );
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (chain[CELLS].lane[k].force_zero) begin
            pix[k] = 8'd0;
         end else if (chain[CELLS].lane[k].force_max) begin
            pix[k] = 8'd255;
         end else begin
            pix[k] = chain[CELLS].lane[k].quo;
         end
      end
      rsp_data_in.pa_col      = pix[0];
      rsp_data_in.pa_row      = pix[1];
      rsp_data_in.pb_col      = pix[2];
      rsp_data_in.pb_row      = pix[3];
      rsp_data_in.pc_col      = pix[4];
      rsp_data_in.pc_row      = pix[5];
      rsp_data_in.colour_out  = chain[CELLS].colour;
      rsp_data_in.shade_level = chain[CELLS].shade;
      rsp_data_in.depth_fault = chain[CELLS].fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[CELLS].valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/tpp_checker.sv =====
`include "triangle_perspective_projection_top_assert.svh"

module tpp_assert_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input tpp_pkg::tpp_req_type req_data,
   input logic                 rsp_valid,
   input tpp_pkg::tpp_rsp_type rsp_data
);
   import tpp_pkg::*;

   logic bad_depth;

   assign bad_depth = req_data.az[15] || (req_data.az == 16'sd0)
                   || req_data.bz[15] || (req_data.bz == 16'sd0)
                   || req_data.cz[15] || (req_data.cz == 16'sd0);

   `TPP_ASSERT_NEVER(a_never_busy, busy, "busy raised")
   `TPP_ASSERT_IMP(a_latency, start && !busy, ##LATENCY rsp_valid, "result missing")
   `TPP_ASSERT_IMP(a_no_spurious, rsp_valid, $past(start && !busy, LATENCY), "spurious result")
   `TPP_ASSERT_IMP(a_fault_match, rsp_valid, rsp_data.depth_fault == $past(bad_depth, LATENCY), "depth fault mismatch")

endmodule

bind triangle_perspective_projection_top tpp_assert_checker u_tpp_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
